// ----- sv/gbn_pkg.sv -----
// Shared types and constants for the go-back-N sender: request and result
// layouts, configuration register indexes, reset values and store controls.
// No dependencies.
package gbn_pkg;

  // Input request: a tick with a send opportunity, or a received acknowledgement.
  typedef struct packed {
    logic        mode;
    logic [7:0]  new_data;
    logic [15:0] ack_seq;
  } gbn_in_t;

  // One result per request.
  typedef struct packed {
    logic        send_valid;
    logic        is_resend;
    logic [15:0] send_seq;
    logic [7:0]  send_data;
    logic [7:0]  send_source;
    logic [7:0]  send_target;
    logic        timed_out;
    logic        ack_taken;
    logic        ack_dropped;
  } gbn_out_t;

  // Configuration register values as seen by the control logic.
  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic [7:0]  source_id;
    logic [7:0]  target_id;
  } gbn_cfg_t;

  // Write enables from the control logic into the window store.
  typedef struct packed {
    logic time_we;
    logic data_we;
  } gbn_wr_t;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd2;

  localparam logic [31:0] TIMEOUT_RST = 32'd6000;
  localparam logic [7:0]  SOURCE_RST  = 8'd0;
  localparam logic [7:0]  TARGET_RST  = 8'd3;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_ACK  = 1'b1;

endpackage

// ----- sv/go_back_n_sender.sv -----
// Go-back-N sender: one result per request, registered in the result register (the
// request is processed while it sits in the input register, once the result register
// can take its result), and one request accepted per cycle while results are taken.
// The rate is set by the update of the sequence and timer state for each request.
// Reset is asynchronous and active low: counters, window base, next and highest
// sequence, send times and configuration return to their defaults; stored bytes do not.
module go_back_n_sender
  import gbn_pkg::*;
#(
  parameter int unsigned WINDOW    = 4,
  parameter int unsigned SEQ_BITS  = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gbn_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gbn_out_t              out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Configuration registers. Writes are always taken; the host must write only while no
  // request is in flight, so no request sees a half-updated set; the block does not enforce it.
  gbn_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT: cfg_d.timeout_ticks = cfg_data_i;
        CFG_SOURCE:  cfg_d.source_id     = cfg_data_i[7:0];
        CFG_TARGET:  cfg_d.target_id     = cfg_data_i[7:0];
        default:     cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.source_id     <= SOURCE_RST;
      cfg_q.target_id     <= TARGET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Two-register pipeline. The input register holds the accepted request; it is
  // processed in the cycle the result register can take its result, which is
  // whenever the result register is empty or its result is being taken.
  gbn_in_t  in_q;
  logic     in_vld_q, in_vld_d;
  gbn_out_t out_q, result;
  logic     out_vld_q, out_vld_d;
  logic     advance, proc;

  assign advance    = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_vld_d   = in_stall_o ? 1'b1 : in_valid_i;
  assign out_vld_d  = advance ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (proc) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // State update and decision logic, and the per-slot window store.
  logic [SLOT_W-1:0]    base_slot, slot;
  gbn_wr_t              wr;
  logic [7:0]           wr_data, stored_byte;
  logic [TIME_BITS-1:0] wr_time, base_time;

  gbn_ctrl #(
    .WINDOW    (WINDOW),
    .SEQ_BITS  (SEQ_BITS),
    .TIME_BITS (TIME_BITS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .proc_i        (proc),
    .item_i        (in_q),
    .cfg_i         (cfg_q),
    .base_time_i   (base_time),
    .stored_byte_i (stored_byte),
    .base_slot_o   (base_slot),
    .slot_o        (slot),
    .wr_o          (wr),
    .wr_data_o     (wr_data),
    .wr_time_o     (wr_time),
    .result_o      (result)
  );

  gbn_store #(
    .WINDOW    (WINDOW),
    .TIME_BITS (TIME_BITS),
    .SLOT_W    (SLOT_W)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .wr_slot_i   (slot),
    .wr_data_i   (wr_data),
    .wr_time_i   (wr_time),
    .time_slot_i (base_slot),
    .time_o      (base_time),
    .data_slot_i (slot),
    .data_o      (stored_byte)
  );

  // A processed request always leaves a result in the next cycle.
  a_proc_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_vld_q)
    else $error("processed request left no result");

  // A result that is held back stays in the result register unchanged.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("held result changed");

  // An acknowledgement is either taken or dropped and never sends a packet.
  a_ack_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_q.mode == MODE_ACK) |=>
      ($onehot({out_q.ack_taken, out_q.ack_dropped})
       && !out_q.send_valid && !out_q.timed_out))
    else $error("bad acknowledgement result");

  // A tick never reports acknowledgement status, and a resend is always a send.
  a_tick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_q.mode == MODE_TICK) |=>
      (!out_q.ack_taken && !out_q.ack_dropped
       && (out_q.send_valid || !out_q.is_resend)))
    else $error("bad tick result");

endmodule

// ----- sv/gbn_store.sv -----
// Window store of the go-back-N sender: payload byte and send time per slot.
// Depends on gbn_pkg for the write-enable struct.
module gbn_store
  import gbn_pkg::*;
#(
  parameter int unsigned WINDOW    = 4,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gbn_wr_t              wr_i,
  input  logic [SLOT_W-1:0]    wr_slot_i,
  input  logic [7:0]           wr_data_i,
  input  logic [TIME_BITS-1:0] wr_time_i,
  input  logic [SLOT_W-1:0]    time_slot_i,
  output logic [TIME_BITS-1:0] time_o,
  input  logic [SLOT_W-1:0]    data_slot_i,
  output logic [7:0]           data_o
);

  logic [7:0]           data_q [WINDOW];
  logic [TIME_BITS-1:0] time_q [WINDOW];

  // Payload bytes are only read back for packets already sent, so they need no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.data_we) begin
      data_q[wr_slot_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        time_q[i] <= '0;
      end
    end else if (wr_i.time_we) begin
      time_q[wr_slot_i] <= wr_time_i;
    end
  end

  assign time_o = time_q[time_slot_i];
  assign data_o = data_q[data_slot_i];

endmodule

// ----- sv/gbn_ctrl.sv -----
// Sequence and timer state of the go-back-N sender with the per-request
// decision logic (timeout, window check, resend, acknowledgement match).
// Depends on gbn_pkg; reads and writes the window store through its ports.
module gbn_ctrl
  import gbn_pkg::*;
#(
  parameter int unsigned WINDOW    = 4,
  parameter int unsigned SEQ_BITS  = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 proc_i,
  input  gbn_in_t              item_i,
  input  gbn_cfg_t             cfg_i,
  input  logic [TIME_BITS-1:0] base_time_i,
  input  logic [7:0]           stored_byte_i,
  output logic [SLOT_W-1:0]    base_slot_o,
  output logic [SLOT_W-1:0]    slot_o,
  output gbn_wr_t              wr_o,
  output logic [7:0]           wr_data_o,
  output logic [TIME_BITS-1:0] wr_time_o,
  output gbn_out_t             result_o
);

  localparam longint unsigned SEQ_MAX   = (64'd1 << SEQ_BITS) - 64'd1;
  localparam longint unsigned WIN_LIMIT = (WINDOW < SEQ_MAX) ? WINDOW : SEQ_MAX;
  localparam logic [SEQ_BITS-1:0] LIMIT    = SEQ_BITS'(WIN_LIMIT);
  localparam logic [SEQ_BITS-1:0] SEQ_TOP  = SEQ_BITS'(SEQ_MAX);
  localparam logic [SLOT_W-1:0]   SLOT_TOP = SLOT_W'(WINDOW - 1);
  localparam int unsigned CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Slot of seq + 1, given the slot of seq. The sequence space wraps to zero,
  // which is slot zero even when the window does not divide that space.
  function automatic logic [SLOT_W-1:0] slot_step(input logic [SEQ_BITS-1:0] seq,
                                                  input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] res;
    if (seq == SEQ_TOP || slot == SLOT_TOP) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

  logic [TIME_BITS-1:0] tick_q, tick_d;
  logic [SEQ_BITS-1:0]  base_q, base_d;
  logic [SEQ_BITS-1:0]  next_q, next_d;
  logic [SEQ_BITS-1:0]  high_q, high_d;
  logic [SLOT_W-1:0]    base_slot_q, base_slot_d;
  logic [SLOT_W-1:0]    next_slot_q, next_slot_d;

  logic [TIME_BITS-1:0] tick_inc, age;
  logic [SEQ_BITS-1:0]  dn, dh, hd, high_far;
  logic [SEQ_BITS-1:0]  dn2, dh2, seq2, seq3, base_inc;
  logic [SLOT_W-1:0]    slot2, slot3, base_slot_inc;
  logic                 is_tick, outstanding, fire, send, resend, grow, match;

  always_comb begin
    tick_inc    = tick_q + 1'b1;
    dn          = next_q - base_q;
    dh          = high_q - base_q;
    hd          = (dn > dh) ? dn : dh;
    high_far    = base_q + hd;
    outstanding = (hd != '0);
    age         = tick_inc - base_time_i;
    is_tick     = (item_i.mode == MODE_TICK);
    fire        = is_tick && outstanding
                  && (CMP_W'(age) > CMP_W'(cfg_i.timeout_ticks));
    // After a rewind sending restarts at the base, with the old reach kept.
    dn2         = fire ? '0 : dn;
    dh2         = fire ? hd : dh;
    seq2        = fire ? base_q : next_q;
    slot2       = fire ? base_slot_q : next_slot_q;
    send        = is_tick && (dn2 < LIMIT);
    resend      = (dn2 < dh2);
    seq3        = seq2 + 1'b1;
    slot3       = slot_step(seq2, slot2);
    grow        = ((dn2 + 1'b1) > dh2);
    base_inc    = base_q + 1'b1;
    base_slot_inc = slot_step(base_q, base_slot_q);
    match       = (SEQ_BITS'(item_i.ack_seq) == base_q) && outstanding;
  end

  always_comb begin
    tick_d      = tick_q;
    base_d      = base_q;
    next_d      = next_q;
    high_d      = high_q;
    base_slot_d = base_slot_q;
    next_slot_d = next_slot_q;
    if (proc_i) begin
      if (is_tick) begin
        tick_d = tick_inc;
        if (fire) begin
          high_d      = high_far;
          next_d      = base_q;
          next_slot_d = base_slot_q;
        end
        if (send) begin
          next_d      = seq3;
          next_slot_d = slot3;
          if (grow) begin
            high_d = seq3;
          end
        end
      end else if (match) begin
        high_d      = high_far;
        base_d      = base_inc;
        base_slot_d = base_slot_inc;
        // An acknowledged packet that was next in line is never resent.
        if (next_q == base_q) begin
          next_d      = base_inc;
          next_slot_d = base_slot_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      base_q      <= '0;
      next_q      <= '0;
      high_q      <= '0;
      base_slot_q <= '0;
      next_slot_q <= '0;
    end else begin
      tick_q      <= tick_d;
      base_q      <= base_d;
      next_q      <= next_d;
      high_q      <= high_d;
      base_slot_q <= base_slot_d;
      next_slot_q <= next_slot_d;
    end
  end

  assign base_slot_o  = base_slot_q;
  assign slot_o       = slot2;
  assign wr_o.time_we = proc_i && send;
  assign wr_o.data_we = proc_i && send && !resend;
  assign wr_data_o    = item_i.new_data;
  assign wr_time_o    = tick_inc;

  always_comb begin
    result_o = '0;
    if (is_tick) begin
      result_o.timed_out = fire;
      if (send) begin
        result_o.send_valid  = 1'b1;
        result_o.is_resend   = resend;
        result_o.send_seq    = 16'(seq2);
        result_o.send_data   = resend ? stored_byte_i : item_i.new_data;
        result_o.send_source = cfg_i.source_id;
        result_o.send_target = cfg_i.target_id;
      end
    end else begin
      result_o.ack_taken   = match;
      result_o.ack_dropped = !match;
    end
  end

endmodule

// ----- sim/gbn_checker.sv -----
// Checker for the go-back-N sender: watches the request, result and register
// channels, keeps its own model of the send window and compares every result.
// Depends on gbn_pkg for the request and result layouts and register indexes.
module gbn_checker
  import gbn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  gbn_in_t               in_item_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  gbn_out_t              out_item_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output logic [15:0]           window_base_o,
  output int                    results_o,
  output int                    resends_o,
  output int                    timeouts_o,
  output int                    acks_taken_o,
  output int                    acks_dropped_o
);

  localparam int unsigned WIN = 4;

  logic [31:0] timeout_q;
  logic [7:0]  source_q;
  logic [7:0]  target_q;

  logic [31:0] ticks;
  logic [15:0] base;
  logic [15:0] next_seq;
  logic [15:0] high_seq;
  logic [7:0]  win_data [WIN];
  logic [31:0] win_time [WIN];

  gbn_out_t results_due [$];

  assign window_base_o = base;

  // Advances the window model by one request and returns the packet decision.
  function automatic gbn_out_t step_window(input gbn_in_t req);
    gbn_out_t    r;
    logic [15:0] dn;
    logic [15:0] dh;
    logic [15:0] hd;
    logic [15:0] old_base;
    logic [31:0] age;
    int          slot;
    r  = '0;
    dn = next_seq - base;
    dh = high_seq - base;
    hd = (dn > dh) ? dn : dh;
    if (req.mode == MODE_TICK) begin
      ticks = ticks + 32'd1;
      // The timeout is only checked while something is outstanding.
      if (hd != 16'd0) begin
        age = ticks - win_time[base % WIN];
        if (age > timeout_q) begin
          high_seq    = base + hd;
          next_seq    = base;
          r.timed_out = 1'b1;
        end
      end
      dn = next_seq - base;
      dh = high_seq - base;
      if (dn < WIN && dn != 16'hFFFF) begin
        slot          = next_seq % WIN;
        r.send_valid  = 1'b1;
        r.send_seq    = next_seq;
        r.send_source = source_q;
        r.send_target = target_q;
        if (dn < dh) begin
          r.is_resend = 1'b1;
        end else begin
          win_data[slot] = req.new_data;
        end
        r.send_data    = win_data[slot];
        win_time[slot] = ticks;
        next_seq       = next_seq + 16'd1;
        dn             = next_seq - base;
        if (dn > dh) begin
          high_seq = next_seq;
        end
      end
    end else begin
      if (req.ack_seq == base && hd != 16'd0) begin
        old_base = base;
        high_seq = base + hd;
        base     = base + 16'd1;
        // A packet rewound to but not yet resent must not go out again.
        if (next_seq == old_base) begin
          next_seq = base;
        end
        r.ack_taken = 1'b1;
      end else begin
        r.ack_dropped = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic int field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gbn_out_t want;
    int       bad;
    if (!rst_ni) begin
      timeout_q = TIMEOUT_RST;
      source_q  = SOURCE_RST;
      target_q  = TARGET_RST;
      ticks     = '0;
      base      = '0;
      next_seq  = '0;
      high_seq  = '0;
      for (int i = 0; i < WIN; i++) begin
        win_data[i] = '0;
        win_time[i] = '0;
      end
      results_due.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      results_o      = 0;
      resends_o      = 0;
      timeouts_o     = 0;
      acks_taken_o   = 0;
      acks_dropped_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TIMEOUT: timeout_q = cfg_data_i;
          CFG_SOURCE:  source_q  = cfg_data_i[7:0];
          CFG_TARGET:  target_q  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(step_window(in_item_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          bad  = 0;
          bad += field_bad("send_valid", 32'(want.send_valid),
                           32'(out_item_i.send_valid));
          bad += field_bad("is_resend", 32'(want.is_resend), 32'(out_item_i.is_resend));
          bad += field_bad("send_seq", 32'(want.send_seq), 32'(out_item_i.send_seq));
          bad += field_bad("send_data", 32'(want.send_data), 32'(out_item_i.send_data));
          bad += field_bad("send_source", 32'(want.send_source),
                           32'(out_item_i.send_source));
          bad += field_bad("send_target", 32'(want.send_target),
                           32'(out_item_i.send_target));
          bad += field_bad("timed_out", 32'(want.timed_out), 32'(out_item_i.timed_out));
          bad += field_bad("ack_taken", 32'(want.ack_taken), 32'(out_item_i.ack_taken));
          bad += field_bad("ack_dropped", 32'(want.ack_dropped),
                           32'(out_item_i.ack_dropped));
          if (bad != 0) begin
            fail_count_o++;
          end
          results_o++;
          resends_o      += want.is_resend;
          timeouts_o     += want.timed_out;
          acks_taken_o   += want.ack_taken;
          acks_dropped_o += want.ack_dropped;
        end
      end
      pending_o = results_due.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Top of the go-back-N sender testbench: clock, reset, request and register
// stimulus, receiver stalls and the final verdict.
// Depends on gbn_pkg, go_back_n_sender and gbn_checker.
module tb;
  import gbn_pkg::*;

  localparam int NPHASE    = 6;
  localparam int PHASE_LEN = 216;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  gbn_in_t               in_item   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  gbn_out_t              out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Percent of cycles in which the request side holds back or the result side
  // stalls; the stimulus process changes them between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int          fail_count;
  int          pending;
  logic [15:0] chk_base;
  int          n_results;
  int          n_resends;
  int          n_timeouts;
  int          n_taken;
  int          n_dropped;

  go_back_n_sender uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gbn_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_item_i      (in_item),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_item_i     (out_item),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .window_base_o  (chk_base),
    .results_o      (n_results),
    .resends_o      (n_resends),
    .timeouts_o     (n_timeouts),
    .acks_taken_o   (n_taken),
    .acks_dropped_o (n_dropped)
  );

  always #1 clk = ~clk;

  // The receiver decides its stall for the next cycle at every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

  // Offers one request. It is entered at a falling edge and returns at the
  // falling edge after acceptance, without touching in_valid in that step, so
  // the next request can keep valid high without a second assignment.
  task automatic send_req(input gbn_in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic req_tick(input logic [7:0] data);
    gbn_in_t req;
    req          = '0;
    req.mode     = MODE_TICK;
    req.new_data = data;
    send_req(req);
  endtask

  task automatic req_ack(input logic [15:0] seq);
    gbn_in_t req;
    req         = '0;
    req.mode    = MODE_ACK;
    req.ack_seq = seq;
    send_req(req);
  endtask

  // Stops offering requests until every predicted result has been taken, then
  // lets the pipeline settle completely.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Leaves cfg_valid high on return so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] timeout, input logic [7:0] src,
                            input logic [7:0] dst);
    write_reg(CFG_TIMEOUT, timeout);
    write_reg(CFG_SOURCE, {24'd0, src});
    write_reg(CFG_TARGET, {24'd0, dst});
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    gbn_in_t     req;
    logic [31:0] t_val;
    logic [7:0]  s_val;
    logic [7:0]  g_val;
    int          tick_pct;
    int          pick;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset settings (timeout 6000, source 0,
    // target 3). An acknowledgement equal to the base is dropped while nothing
    // is outstanding, the window fills and refuses a fifth packet, a wrong
    // acknowledgement is dropped and the right one slides the window.
    req_ack(16'h0000);
    req_ack(16'hFFFF);
    req_tick(8'h00);
    req_tick(8'hFF);
    req_tick(8'hA5);
    req_tick(8'h5A);
    req_tick(8'h77);
    req_ack(16'h0002);
    req_ack(16'h0000);
    req_tick(8'hC3);
    wait_idle();

    // With the shortest timeout the stale base packet is resent at once, the
    // next tick resends the following one, and the third times out again.
    // The second acknowledgement after that lands on the packet that was next
    // to go out after the rewind, which must then be skipped.
    set_config(32'd1, 8'hFF, 8'h00);
    req_tick(8'h11);
    req_tick(8'h22);
    req_tick(8'h33);
    req_ack(chk_base);
    req_ack(chk_base);
    req_tick(8'h44);
    req_ack(16'h8000);
    req_ack(chk_base);
    req_ack(chk_base);
    req_ack(chk_base);
    wait_idle();

    // Random phases. Each one uses its own register settings and mix of ticks
    // and acknowledgements. Most acknowledgements carry the base the checker
    // predicts so the window keeps sliding; the rest are near misses, stale
    // numbers or noise.
    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: begin
          t_val = 32'd3;  s_val = 8'h12; g_val = 8'h34; tick_pct = 55;
        end
        1: begin
          t_val = 32'd1;  s_val = 8'hFF; g_val = 8'hFF; tick_pct = 60;
        end
        2: begin
          t_val = 32'hFFFF_FFFF; s_val = 8'h00; g_val = 8'h00; tick_pct = 50;
        end
        3: begin
          t_val = 32'd12; s_val = 8'($urandom_range(255));
          g_val = 8'($urandom_range(255));
          tick_pct = 65;
        end
        4: begin
          t_val = 32'd2;  s_val = 8'($urandom_range(255));
          g_val = 8'($urandom_range(255));
          tick_pct = 45;
        end
        default: begin
          t_val = 32'd40; s_val = 8'($urandom_range(255));
          g_val = 8'($urandom_range(255));
          tick_pct = 55;
        end
      endcase
      // First the sender rarely idles while the receiver mostly stalls, then
      // the roles swap, and the last phases run at full rate.
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 75;
      end else if (p < 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_config(t_val, s_val, g_val);

      for (int k = 0; k < PHASE_LEN; k++) begin
        req          = '0;
        req.new_data = 8'($urandom_range(255));
        req.ack_seq  = 16'($urandom_range(16'hFFFF));
        if ($urandom_range(99) < tick_pct) begin
          req.mode = MODE_TICK;
        end else begin
          req.mode = MODE_ACK;
          pick     = $urandom_range(99);
          if (pick < 75) begin
            req.ack_seq = chk_base;
          end else if (pick < 85) begin
            req.ack_seq = chk_base + 16'($urandom_range(4, 1));
          end else if (pick < 90) begin
            req.ack_seq = chk_base - 16'd1;
          end
        end
        send_req(req);
        // Now and then the sender holds off until the block has drained.
        if (k == 100 || $urandom_range(199) == 0) begin
          wait_idle();
        end
      end
      wait_idle();
    end

    if (pending != 0) begin
      $error("%0d results never arrived", pending);
    end
    $display("Checked %0d results over %0d register settings: %0d resends, %0d timeouts.",
             n_results, NPHASE + 2, n_resends, n_timeouts);
    $display("Acknowledgements: %0d slid the window, %0d were dropped.",
             n_taken, n_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
